// File: hdl/gqtl_pkg.sv
`default_nettype none
package gqtl_pkg;

    localparam int MaxChars   = 16;
    localparam int GlyphCount = 256;

    // Item kinds.
    localparam logic [1:0] KindLoad  = 2'd0;
    localparam logic [1:0] KindColor = 2'd1;
    localparam logic [1:0] KindChar  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] RegRectLeft    = 3'd0;
    localparam logic [2:0] RegRectRight   = 3'd1;
    localparam logic [2:0] RegRectTop     = 3'd2;
    localparam logic [2:0] RegRectBottom  = 3'd3;
    localparam logic [2:0] RegAlignMode   = 3'd4;
    localparam logic [2:0] RegCharScale   = 3'd5;
    localparam logic [2:0] RegScreenWidth = 3'd6;
    localparam logic [2:0] RegScreenHeight = 3'd7;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SIZE_RD,
        ST_SIZE_ACC,
        ST_ALIGN,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_X,
        ST_EMIT_Y,
        ST_EMIT_OUT
    } state_t;

    // Saturate a Q.14 pixel product to a Q24.8 word, floor by 64.
    function automatic logic [31:0] to_screen(input logic signed [47:0] prod);
        logic signed [41:0] q;
        begin
            q = 42'(prod >>> 6);
            if (q > 42'sd2147483647)
                to_screen = 32'h7FFF_FFFF;
            else if (q < -42'sd2147483648)
                to_screen = 32'h8000_0000;
            else
                to_screen = q[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/gqtl_ram.sv
`default_nettype none
module gqtl_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: hdl/glyph_quad_text_layout_unit.sv
// Text quad layout unit.
// s_axis carries one input word: a glyph load, a corner color or a text
// character. Characters are buffered; the one with tlast set starts layout.
// m_axis emits four vertex words per buffered character (left-top,
// left-bottom, right-top, right-bottom); tlast marks the final vertex.
// cfg writes one of eight layout registers by index while the unit is idle.
// A load, color or unmarked character is accepted while the unit is idle,
// so such words can follow back to back. A marked run of N characters then
// goes through the sizing pass, a table read and an accumulate step per
// character, and alignment. The emit pass then reads the tables once per
// character and steps each vertex through EMIT_MUL, EMIT_X, EMIT_Y and
// EMIT_OUT, using the shared multiplier for the screen x and y coordinates;
// scaled glyph sizes come from two narrow 16x16 products.
// After reset a clearing pass zeroes every glyph table entry; s_axis and
// cfg are not ready during it. When the receiver stalls, the vertex word
// holds in the output register and the sequencer waits.
`default_nettype none
module glyph_quad_text_layout_unit #(
    parameter int MaxChars   = gqtl_pkg::MaxChars,
    parameter int GlyphCount = gqtl_pkg::GlyphCount
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // kind[1:0], glyph_code[9:2], glyph_width[25:10], glyph_height[41:26],
    // tex_left[57:42], tex_right[73:58], tex_top[89:74], tex_bottom[105:90],
    // corner[107:106], color_value[139:108], zero fill [143:140]
    input  wire logic [143:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,   // end_of_text
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // vertex_x[31:0], vertex_y[63:32], vertex_u[79:64], vertex_v[95:80],
    // vertex_color[127:96]
    output logic      [127:0] m_axis_tdata,
    output logic              m_axis_tlast,   // last_vertex
    output logic              m_axis_tuser,   // truncated
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int GW = (GlyphCount > 1) ? $clog2(GlyphCount) : 1;
    localparam int CW = (MaxChars > 1) ? $clog2(MaxChars) : 1;
    localparam int NW = $clog2(MaxChars + 1);

    gqtl_pkg::state_t state_reg, state_next;

    logic signed [15:0] rl_reg, rr_reg, rt_reg, rb_reg;
    logic [3:0]  align_reg;
    logic [15:0] scale_reg;
    logic [13:0] sw_reg, sh_reg;
    logic [31:0] col_reg [4];
    logic [7:0]  tbuf_reg [MaxChars];
    logic [NW-1:0] cnt_reg;
    logic        ovf_reg;
    logic [GW:0] clr_reg;
    logic [NW-1:0] idx_reg;
    logic [1:0]  vtx_reg;
    logic signed [23:0] total_reg, tallest_reg;
    logic signed [23:0] bx_reg, by_reg, nw_reg, nh_reg;
    logic        ob_reg;

    // Shared multiplier operands and registered product.
    logic signed [24:0] ma, mb;
    logic signed [47:0] prod_reg;
    logic signed [47:0] xprod_reg;

    logic [31:0] size_rd;
    logic [63:0] tex_rd;
    logic        wr_en;
    logic [GW-1:0] wr_addr, rd_addr;
    logic [31:0] size_wd;
    logic [63:0] tex_wd;
    logic [7:0]  code_cur;
    logic        in_acc;
    logic [7:0]  in_code;

    assign in_code = s_axis_tdata[9:2];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == gqtl_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == gqtl_pkg::ST_IDLE);

    // Glyph stores, cleared by a sweep after reset.
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = GW'(in_code);
        size_wd = {s_axis_tdata[25:10], s_axis_tdata[41:26]};
        tex_wd = {s_axis_tdata[57:42], s_axis_tdata[73:58],
                  s_axis_tdata[89:74], s_axis_tdata[105:90]};
        if (state_reg == gqtl_pkg::ST_CLEAR)
        begin
            wr_en = 1'b1;
            wr_addr = clr_reg[GW-1:0];
            size_wd = '0;
            tex_wd = '0;
        end
        else if (in_acc && s_axis_tdata[1:0] == gqtl_pkg::KindLoad
                 && 32'(in_code) < 32'(GlyphCount))
        begin
            wr_en = 1'b1;
        end
    end

    assign code_cur = tbuf_reg[idx_reg[CW-1:0]];
    assign rd_addr = GW'(code_cur);

    gqtl_ram #(.Width(32), .Depth(GlyphCount)) u_size (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(size_wd),
        .rd_addr(rd_addr), .rd_data(size_rd)
    );
    gqtl_ram #(.Width(64), .Depth(GlyphCount)) u_tex (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(tex_wd),
        .rd_addr(rd_addr), .rd_data(tex_rd)
    );

    // Codes beyond the table read as zero.
    logic code_ok_reg;
    logic [31:0] size_v;
    logic [63:0] tex_v;
    assign size_v = code_ok_reg ? size_rd : '0;
    assign tex_v = code_ok_reg ? tex_rd : '0;

    logic [3:0] mode;
    logic [1:0] hm, vm;
    assign mode = (align_reg > 4'd8) ? 4'd0 : align_reg;
    always_comb
    begin
        case (mode)
            4'd0: begin hm = 2'd0; vm = 2'd0; end
            4'd1: begin hm = 2'd1; vm = 2'd0; end
            4'd2: begin hm = 2'd2; vm = 2'd0; end
            4'd3: begin hm = 2'd0; vm = 2'd1; end
            4'd4: begin hm = 2'd1; vm = 2'd1; end
            4'd5: begin hm = 2'd2; vm = 2'd1; end
            4'd6: begin hm = 2'd0; vm = 2'd2; end
            4'd7: begin hm = 2'd1; vm = 2'd2; end
            default: begin hm = 2'd2; vm = 2'd2; end
        endcase
    end

    // Vertex selection: corners in order left-top, left-bottom, right-top,
    // right-bottom.
    logic right_side, bottom_side;
    assign right_side = vtx_reg[1];
    assign bottom_side = vtx_reg[0];

    logic signed [24:0] vx, vy;
    assign vx = right_side ? 25'(bx_reg) + 25'(nw_reg) : 25'(bx_reg);
    assign vy = bottom_side ? 25'(by_reg) + 25'(nh_reg) : 25'(by_reg);

    // Shared multiplier operand selection. The y product is held while the
    // output register waits.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            gqtl_pkg::ST_EMIT_MUL:
            begin
                ma = vx;
                mb = 25'({1'b0, sw_reg});
            end
            gqtl_pkg::ST_EMIT_X, gqtl_pkg::ST_EMIT_Y:
            begin
                ma = vy;
                mb = 25'({1'b0, sh_reg});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Glyph height and width scaling use two narrow products.
    logic [31:0] hprod;
    assign hprod = size_v[15:0] * scale_reg;
    logic [31:0] hprod_w;
    assign hprod_w = size_v[31:16] * scale_reg;

    logic signed [25:0] dxh, dyh;
    assign dxh = 26'(rr_reg) - 26'(rl_reg) - 26'(total_reg);
    assign dyh = 26'(rb_reg) - 26'(rt_reg) - 26'(tallest_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gqtl_pkg::ST_CLEAR:
                if (clr_reg == (GW+1)'(GlyphCount - 1))
                    state_next = gqtl_pkg::ST_IDLE;
            gqtl_pkg::ST_IDLE:
                if (in_acc && s_axis_tdata[1:0] == gqtl_pkg::KindChar && s_axis_tlast)
                    state_next = gqtl_pkg::ST_SIZE_RD;
            gqtl_pkg::ST_SIZE_RD:
                if (idx_reg == cnt_reg)
                    state_next = gqtl_pkg::ST_ALIGN;
                else
                    state_next = gqtl_pkg::ST_SIZE_ACC;
            gqtl_pkg::ST_SIZE_ACC:
                state_next = gqtl_pkg::ST_SIZE_RD;
            gqtl_pkg::ST_ALIGN:
                if (cnt_reg == '0)
                    state_next = gqtl_pkg::ST_IDLE;
                else
                    state_next = gqtl_pkg::ST_EMIT_RD;
            gqtl_pkg::ST_EMIT_RD:
                state_next = gqtl_pkg::ST_EMIT_MUL;
            gqtl_pkg::ST_EMIT_MUL:
                state_next = gqtl_pkg::ST_EMIT_X;
            gqtl_pkg::ST_EMIT_X:
                state_next = gqtl_pkg::ST_EMIT_Y;
            gqtl_pkg::ST_EMIT_Y:
                if (!ob_reg || m_axis_tready)
                    state_next = gqtl_pkg::ST_EMIT_OUT;
            gqtl_pkg::ST_EMIT_OUT:
                if (vtx_reg == 2'd3 && idx_reg + NW'(1) == cnt_reg)
                    state_next = gqtl_pkg::ST_IDLE;
                else if (vtx_reg == 2'd3)
                    state_next = gqtl_pkg::ST_EMIT_RD;
                else
                    state_next = gqtl_pkg::ST_EMIT_MUL;
            default:
                state_next = gqtl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gqtl_pkg::ST_CLEAR;
            clr_reg <= '0;
            rl_reg <= 16'sd0;
            rr_reg <= 16'sd16384;
            rt_reg <= 16'sd0;
            rb_reg <= 16'sd16384;
            align_reg <= 4'd0;
            scale_reg <= 16'd4096;
            sw_reg <= 14'd640;
            sh_reg <= 14'd480;
            for (int i = 0; i < 4; i++)
                col_reg[i] <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
            vtx_reg <= '0;
            ob_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gqtl_pkg::ST_CLEAR)
                clr_reg <= clr_reg + (GW+1)'(1);

            // Configuration writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gqtl_pkg::RegRectLeft:     rl_reg <= cfg_data;
                    gqtl_pkg::RegRectRight:    rr_reg <= cfg_data;
                    gqtl_pkg::RegRectTop:      rt_reg <= cfg_data;
                    gqtl_pkg::RegRectBottom:   rb_reg <= cfg_data;
                    gqtl_pkg::RegAlignMode:    align_reg <= cfg_data[3:0];
                    gqtl_pkg::RegCharScale:    scale_reg <= cfg_data;
                    gqtl_pkg::RegScreenWidth:  sw_reg <= cfg_data[13:0];
                    gqtl_pkg::RegScreenHeight: sh_reg <= cfg_data[13:0];
                    default:
                    begin
                    end
                endcase
            end

            // Input words.
            if (in_acc)
            begin
                if (s_axis_tdata[1:0] == gqtl_pkg::KindColor)
                    col_reg[s_axis_tdata[107:106]] <= s_axis_tdata[139:108];
                if (s_axis_tdata[1:0] == gqtl_pkg::KindChar)
                begin
                    if (cnt_reg < NW'(MaxChars))
                        cnt_reg <= cnt_reg + NW'(1);
                    else
                        ovf_reg <= 1'b1;
                    idx_reg <= '0;
                end
            end

            // Output register handshake: load a new vertex word or release
            // the accepted one.
            if (state_reg == gqtl_pkg::ST_EMIT_Y && (!ob_reg || m_axis_tready))
                ob_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                ob_reg <= 1'b0;

            case (state_reg)
                gqtl_pkg::ST_SIZE_ACC:
                    idx_reg <= idx_reg + NW'(1);
                gqtl_pkg::ST_ALIGN:
                begin
                    idx_reg <= '0;
                    vtx_reg <= '0;
                    if (cnt_reg == '0)
                        ovf_reg <= 1'b0;
                end
                gqtl_pkg::ST_EMIT_OUT:
                begin
                    vtx_reg <= vtx_reg + 2'd1;
                    if (vtx_reg == 2'd3)
                    begin
                        idx_reg <= idx_reg + NW'(1);
                        if (idx_reg + NW'(1) == cnt_reg)
                        begin
                            cnt_reg <= '0;
                            ovf_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tdata[1:0] == gqtl_pkg::KindChar
            && cnt_reg < NW'(MaxChars))
            tbuf_reg[cnt_reg[CW-1:0]] <= in_code;
        code_ok_reg <= 32'(code_cur) < 32'(GlyphCount);
        prod_reg <= ma * mb;
        case (state_reg)
            gqtl_pkg::ST_IDLE:
            begin
                total_reg <= '0;
                tallest_reg <= '0;
            end
            gqtl_pkg::ST_SIZE_ACC:
            begin
                total_reg <= total_reg + 24'(hprod_w >> 14);
                if (24'(hprod >> 14) > tallest_reg)
                    tallest_reg <= 24'(hprod >> 14);
            end
            gqtl_pkg::ST_ALIGN:
            begin
                case (hm)
                    2'd0: bx_reg <= 24'(rl_reg);
                    2'd1: bx_reg <= 24'(rr_reg) - total_reg;
                    default: bx_reg <= 24'(rl_reg) + 24'(dxh >>> 1);
                endcase
                case (vm)
                    2'd0: by_reg <= 24'(rt_reg);
                    2'd1: by_reg <= 24'(rb_reg) - tallest_reg;
                    default: by_reg <= 24'(rt_reg) + 24'(dyh >>> 1);
                endcase
            end
            gqtl_pkg::ST_EMIT_RD:
            begin
            end
            gqtl_pkg::ST_EMIT_MUL:
            begin
                if (vtx_reg == 2'd0)
                begin
                    nw_reg <= 24'(hprod_w >> 14);
                    nh_reg <= 24'(hprod >> 14);
                end
            end
            gqtl_pkg::ST_EMIT_X:
                xprod_reg <= prod_reg;
            gqtl_pkg::ST_EMIT_Y:
            begin
                if (!ob_reg || m_axis_tready)
                begin
                    m_axis_tdata[31:0] <= gqtl_pkg::to_screen(xprod_reg);
                    m_axis_tdata[63:32] <= gqtl_pkg::to_screen(prod_reg);
                    m_axis_tdata[79:64] <= right_side ? tex_v[47:32] : tex_v[63:48];
                    m_axis_tdata[95:80] <= bottom_side ? tex_v[15:0] : tex_v[31:16];
                    m_axis_tdata[127:96] <= col_reg[{bottom_side, right_side}];
                    m_axis_tlast <= (vtx_reg == 2'd3) && (idx_reg + NW'(1) == cnt_reg);
                    m_axis_tuser <= ovf_reg;
                end
            end
            gqtl_pkg::ST_EMIT_OUT:
                // The next character starts at the right edge of this one.
                if (vtx_reg == 2'd3)
                    bx_reg <= bx_reg + nw_reg;
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = ob_reg;

endmodule
`default_nettype wire

// File: test/tb_glyph_quad_text_layout_unit.sv
`default_nettype none
module tb_glyph_quad_text_layout_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind code that the unit ignores.
    localparam logic [1:0] KindUnused = 2'd3;

    // One input word as the layout unit sees it.
    typedef struct packed {
        logic [31:0] color_value;
        logic [1:0]  corner;
        logic [15:0] tex_bottom;
        logic [15:0] tex_top;
        logic [15:0] tex_right;
        logic [15:0] tex_left;
        logic [15:0] glyph_height;
        logic [15:0] glyph_width;
        logic [7:0]  glyph_code;
        logic [1:0]  kind;
    } text_word_t;

    // One vertex word.
    typedef struct packed {
        logic        truncated;
        logic        last_vertex;
        logic [31:0] vertex_color;
        logic [15:0] vertex_v;
        logic [15:0] vertex_u;
        logic [31:0] vertex_y;
        logic [31:0] vertex_x;
    } vertex_t;

    // Pending stimulus: a word, or a register write, or a drain request.
    typedef struct packed {
        logic        is_cfg;
        logic        drain;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mark;
        text_word_t  word;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    glyph_quad_text_layout_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state.
    logic [31:0] glyph_size [gqtl_pkg::GlyphCount];
    logic [63:0] glyph_tex [gqtl_pkg::GlyphCount];
    logic [7:0]  run_codes [gqtl_pkg::MaxChars];
    int unsigned run_len;
    logic        run_lost;
    logic [31:0] corner_rgba [4];
    logic [15:0] layout_reg [8];

    vertex_t expected_vertices [$];
    pending_t pending [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit stimulus_done = 1'b0;
    bit quiet_phase = 1'b0;

    function automatic longint sext16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint floor_half(longint x);
        return x >>> 1;
    endfunction

    function automatic logic [31:0] pixel_word(longint pos, logic [15:0] dim);
        longint q;
        q = (pos * longint'(dim[13:0])) >>> 6;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic longint scale_size(logic [15:0] size);
        return longint'((64'(size) * 64'(layout_reg[gqtl_pkg::RegCharScale])) >> 14);
    endfunction

    function automatic void push_vertex(longint x, longint y, logic [15:0] u,
                                        logic [15:0] v, logic [31:0] color);
        vertex_t vx;
        vx.vertex_x = pixel_word(x, layout_reg[gqtl_pkg::RegScreenWidth]);
        vx.vertex_y = pixel_word(y, layout_reg[gqtl_pkg::RegScreenHeight]);
        vx.vertex_u = u;
        vx.vertex_v = v;
        vx.vertex_color = color;
        vx.last_vertex = 1'b0;
        vx.truncated = run_lost;
        expected_vertices.push_back(vx);
    endfunction

    // Apply one accepted word to the predictor and queue the vertices it causes.
    function automatic void layout_word(text_word_t w, logic mark);
        longint total, tallest, bx, by, hh, nw, lft, rgt, tp, bt;
        int unsigned mode;
        logic [31:0] sz;
        logic [63:0] tx;
        total = 0;
        tallest = 0;
        if (w.kind == gqtl_pkg::KindLoad)
        begin
            glyph_size[w.glyph_code] = {w.glyph_width, w.glyph_height};
            glyph_tex[w.glyph_code] = {w.tex_left, w.tex_right, w.tex_top, w.tex_bottom};
            return;
        end
        if (w.kind == gqtl_pkg::KindColor)
        begin
            corner_rgba[w.corner] = w.color_value;
            return;
        end
        if (w.kind != gqtl_pkg::KindChar) return;
        if (run_len < gqtl_pkg::MaxChars)
        begin
            run_codes[run_len] = w.glyph_code;
            run_len++;
        end
        else
            run_lost = 1'b1;
        if (!mark) return;

        // Sizing pass.
        for (int i = 0; i < run_len; i++)
        begin
            sz = glyph_size[run_codes[i]];
            total += scale_size(sz[31:16]);
            hh = scale_size(sz[15:0]);
            if (hh > tallest) tallest = hh;
        end

        // Alignment inside the rectangle.
        lft = sext16(layout_reg[gqtl_pkg::RegRectLeft]);
        rgt = sext16(layout_reg[gqtl_pkg::RegRectRight]);
        tp = sext16(layout_reg[gqtl_pkg::RegRectTop]);
        bt = sext16(layout_reg[gqtl_pkg::RegRectBottom]);
        mode = layout_reg[gqtl_pkg::RegAlignMode][3:0];
        if (mode > 8) mode = 0;
        case (mode % 3)
            0: bx = lft;
            1: bx = rgt - total;
            default: bx = lft + floor_half(rgt - lft - total);
        endcase
        case (mode / 3)
            0: by = tp;
            1: by = bt - tallest;
            default: by = tp + floor_half(bt - tp - tallest);
        endcase

        // Emit pass.
        for (int i = 0; i < run_len; i++)
        begin
            sz = glyph_size[run_codes[i]];
            tx = glyph_tex[run_codes[i]];
            nw = scale_size(sz[31:16]);
            hh = scale_size(sz[15:0]);
            push_vertex(bx, by, tx[63:48], tx[31:16], corner_rgba[0]);
            push_vertex(bx, by + hh, tx[63:48], tx[15:0], corner_rgba[2]);
            bx += nw;
            push_vertex(bx, by, tx[47:32], tx[31:16], corner_rgba[1]);
            push_vertex(bx, by + hh, tx[47:32], tx[15:0], corner_rgba[3]);
        end
        if (run_len > 0) expected_vertices[$].last_vertex = 1'b1;
        run_len = 0;
        run_lost = 1'b0;
    endfunction

    function automatic void add_word(logic [1:0] kind, logic [7:0] code, logic mark);
        pending_t p;
        p = '0;
        p.word.kind = kind;
        p.word.glyph_code = code;
        p.word.tex_left = 16'($urandom);
        p.word.tex_right = 16'($urandom);
        p.word.tex_top = 16'($urandom);
        p.word.tex_bottom = 16'($urandom);
        p.word.corner = 2'($urandom);
        p.word.color_value = $urandom;
        p.word.glyph_width = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 4000));
        p.word.glyph_height = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 4000));
        p.mark = mark;
        pending.push_back(p);
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [15:0] val);
        pending_t p;
        p = '0;
        p.drain = 1'b1;
        pending.push_back(p);
        p.drain = 1'b0;
        p.is_cfg = 1'b1;
        p.reg_index = idx;
        p.reg_value = val;
        pending.push_back(p);
    endfunction

    // Stimulus plan.
    initial
    begin
        int n;
        for (int i = 0; i < gqtl_pkg::GlyphCount; i++)
        begin
            glyph_size[i] = '0;
            glyph_tex[i] = '0;
        end
        for (int i = 0; i < 4; i++) corner_rgba[i] = '0;
        run_len = 0;
        run_lost = 1'b0;
        layout_reg = '{16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd4096,
                       16'd640, 16'd480};

        // Directed part: unloaded glyph, extremes, colors, odd kind, overflow.
        add_word(gqtl_pkg::KindChar, 8'd0, 1'b1);
        add_word(gqtl_pkg::KindLoad, 8'd0, 1'b1);
        add_word(gqtl_pkg::KindLoad, 8'd255, 1'b0);
        for (int c = 0; c < 4; c++) add_word(gqtl_pkg::KindColor, 8'(c), c[0]);
        add_word(KindUnused, 8'd7, 1'b1);
        add_word(gqtl_pkg::KindChar, 8'd255, 1'b0);
        add_word(gqtl_pkg::KindChar, 8'd0, 1'b1);
        for (int i = 0; i < 18; i++)
            add_word(gqtl_pkg::KindChar, 8'($urandom_range(0, 1) * 255), i == 17);
        add_cfg(gqtl_pkg::RegCharScale, 16'hFFFF);
        add_cfg(gqtl_pkg::RegScreenWidth, 16'd8192);
        add_cfg(gqtl_pkg::RegScreenHeight, 16'd8192);
        add_cfg(gqtl_pkg::RegRectLeft, 16'h8000);
        add_cfg(gqtl_pkg::RegRectRight, 16'h7FFF);
        add_cfg(gqtl_pkg::RegAlignMode, 16'd8);
        add_word(gqtl_pkg::KindChar, 8'd255, 1'b0);
        add_word(gqtl_pkg::KindChar, 8'd0, 1'b1);

        // Random part: glyph loads and colors mixed with text runs.
        n = 0;
        while (n < 250)
        begin
            if (n % 40 == 39)
            begin
                add_cfg(gqtl_pkg::RegRectLeft, 16'($urandom));
                add_cfg(gqtl_pkg::RegRectRight, 16'($urandom));
                add_cfg(gqtl_pkg::RegRectTop, 16'($urandom));
                add_cfg(gqtl_pkg::RegRectBottom, 16'($urandom));
                add_cfg(gqtl_pkg::RegAlignMode, 16'($urandom_range(0, 15)));
                add_cfg(gqtl_pkg::RegCharScale,
                        ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 8192)));
                add_cfg(gqtl_pkg::RegScreenWidth, 16'($urandom_range(0, 16383)));
                add_cfg(gqtl_pkg::RegScreenHeight,
                        ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom));
            end
            case ($urandom_range(0, 9))
                0, 1: add_word(gqtl_pkg::KindLoad, 8'($urandom), 1'($urandom));
                2: add_word(gqtl_pkg::KindColor, 8'($urandom), 1'($urandom));
                3: add_word(KindUnused, 8'($urandom), 1'($urandom));
                default:
                begin
                    int len;
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 19)
                                                      : $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        add_word(gqtl_pkg::KindChar, 8'($urandom), i == len - 1);
                    n += len - 1;
                end
            endcase
            n++;
        end
        add_cfg(gqtl_pkg::RegCharScale, 16'd0);
        add_word(gqtl_pkg::KindChar, 8'd255, 1'b1);
        add_cfg(gqtl_pkg::RegRectTop, 16'h7FFF);
        add_cfg(gqtl_pkg::RegRectBottom, 16'h8000);
        add_cfg(gqtl_pkg::RegScreenWidth, 16'd1);
        add_cfg(gqtl_pkg::RegScreenHeight, 16'd0);
        add_cfg(gqtl_pkg::RegCharScale, 16'd4096);
        add_word(gqtl_pkg::KindChar, 8'd255, 1'b1);
        stimulus_done = 1'b1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Handshake samples taken at the rising edge, used by the driver.
    logic s_axis_tready_q = 1'b0;
    logic cfg_ready_q = 1'b0;
    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tready;
        cfg_ready_q <= cfg_ready;
        cycle_count <= cycle_count + 1;
        quiet_phase <= (cycle_count > 2000 && cycle_count < 6000);
    end

    // Driver: inputs change on the falling edge.
    int unsigned drain_wait = 0;
    always @(negedge clk)
    begin
        logic s_busy, c_busy, s_load, c_load;
        s_busy = s_axis_tvalid && !s_axis_tready_q;
        c_busy = cfg_valid && !cfg_ready_q;
        s_load = 1'b0;
        c_load = 1'b0;
        if (rst_n && !s_busy && !c_busy && pending.size() > 0)
        begin
            if (pending[0].drain)
            begin
                if (expected_vertices.size() == 0)
                begin
                    if (drain_wait >= 200)
                    begin
                        drain_wait = 0;
                        void'(pending.pop_front());
                    end
                    else
                        drain_wait++;
                end
            end
            else if (pending[0].is_cfg)
            begin
                c_load = 1'b1;
                cfg_index <= pending[0].reg_index;
                cfg_data <= pending[0].reg_value;
                void'(pending.pop_front());
            end
            else if (quiet_phase || $urandom_range(0, 99) >= 23)
            begin
                s_load = 1'b1;
                s_axis_tdata <= {4'b0, pending[0].word};
                s_axis_tlast <= pending[0].mark;
                void'(pending.pop_front());
            end
        end
        s_axis_tvalid <= s_load || s_busy;
        cfg_valid <= c_load || c_busy;
        m_axis_tready <= rst_n && (quiet_phase || ($urandom_range(0, 99) >= 23));
    end

    // Monitor: applies accepted words to the predictor and checks vertices.
    always @(posedge clk)
    begin
        vertex_t got, want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                layout_reg[cfg_index] = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                layout_word(text_word_t'(s_axis_tdata[139:0]), s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
                if (expected_vertices.size() == 0)
                begin
                    $error("unexpected vertex word %h", got);
                    error_count++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got.vertex_x !== want.vertex_x)
                    begin
                        $error("vertex_x expected %h actual %h", want.vertex_x, got.vertex_x);
                        error_count++;
                    end
                    if (got.vertex_y !== want.vertex_y)
                    begin
                        $error("vertex_y expected %h actual %h", want.vertex_y, got.vertex_y);
                        error_count++;
                    end
                    if (got.vertex_u !== want.vertex_u)
                    begin
                        $error("vertex_u expected %h actual %h", want.vertex_u, got.vertex_u);
                        error_count++;
                    end
                    if (got.vertex_v !== want.vertex_v)
                    begin
                        $error("vertex_v expected %h actual %h", want.vertex_v, got.vertex_v);
                        error_count++;
                    end
                    if (got.vertex_color !== want.vertex_color)
                    begin
                        $error("vertex_color expected %h actual %h", want.vertex_color,
                               got.vertex_color);
                        error_count++;
                    end
                    if (got.last_vertex !== want.last_vertex)
                    begin
                        $error("last_vertex expected %b actual %b", want.last_vertex,
                               got.last_vertex);
                        error_count++;
                    end
                    if (got.truncated !== want.truncated)
                    begin
                        $error("truncated expected %b actual %b", want.truncated,
                               got.truncated);
                        error_count++;
                    end
                end
            end
        end
    end

    // End of run: drain, settle, then report; a cycle limit guards it all.
    initial
    begin
        wait (stimulus_done && rst_n);
        while ((pending.size() > 0 || s_axis_tvalid || cfg_valid
                || expected_vertices.size() > 0) && cycle_count < 900000)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (cycle_count >= 900000)
        begin
            $display("[glyph_quad_text_layout_unit] ERROR");
        end
        else if (error_count == 0 && expected_vertices.size() == 0)
        begin
            $display("[glyph_quad_text_layout_unit] OK");
        end
        else
        begin
            $display("[glyph_quad_text_layout_unit] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
